// ----- sv/efrx_pkg.sv -----
// ----------------------------------------------------------------------------
// efrx_pkg
// Shared types and constants for the escaped frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package efrx_pkg;

  // Frame buffer capacity in bytes.
  localparam int FRAME_BYTES = 256;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int LEN_W       = 9;

  localparam logic [7:0] HEAD_BYTE = 8'hFF;
  localparam logic [7:0] TAIL_BYTE = 8'hFE;
  localparam logic [7:0] ESC_BYTE  = 8'hFD;
  localparam logic [7:0] ESC_MIN   = 8'h7D;
  localparam logic [7:0] ESC_ADD   = 8'h80;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  // Result fields other than the read data, which comes from the buffer port.
  typedef struct packed {
    kind_t            result_kind;
    logic             frame_valid;
    logic [7:0]       command_code;
    logic [7:0]       sub_code;
    logic [LEN_W-1:0] frame_length;
    logic             overflowed;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/efrx_ifs.sv -----
// ----------------------------------------------------------------------------
// efrx channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface efrx_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, output opcode, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input opcode, input rx_byte, input read_index,
                  output ready);
endinterface

interface efrx_out_if;
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic                      frame_valid;
  logic [7:0]                command_code;
  logic [7:0]                sub_code;
  logic [efrx_pkg::LEN_W-1:0] frame_length;
  logic                      overflowed;
  logic [7:0]                read_data;

  modport source (output valid, output result_kind, output frame_valid,
                  output command_code, output sub_code, output frame_length,
                  output overflowed, output read_data, input ready);
  modport sink   (input valid, input result_kind, input frame_valid,
                  input command_code, input sub_code, input frame_length,
                  input overflowed, input read_data, output ready);
endinterface

`default_nettype wire

// ----- sv/escaped_frame_receiver_xor_check.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_receiver_xor_check
// Frame buffer for a 0xFF/0xFE framed byte stream with escape and XOR check.
// ----------------------------------------------------------------------------
// Use:
//   in_chan carries one item per handshake: opcode 0 pushes rx_byte into the
//   frame being received, opcode 1 reads the buffer at read_index.
//   out_chan returns one item for every read and for every tail byte (frame
//   status: validity, bytes 3 and 4, length, overflow). Other pushes give none.
// Timing:
//   One item per cycle sustained while out_chan is not stalled. The middle
//   stage and buffer read data are registered at acceptance; out_chan.valid
//   rises when the output register takes over the middle stage's result.
//   Frame state (count, running XOR, last byte, overflow) sits in flip-flops
//   and is updated in the cycle of acceptance, so pushes never wait on
//   one another; the buffer itself is a single-write, single-read memory.
// Reset:
//   Clears count, XOR, last byte, overflow and the pipeline valids. The buffer
//   is not cleared; reading an entry never written returns arbitrary data.
// Stall:
//   While out_chan is stalled one further result item waits in the middle
//   stage; pushes that give no result are still taken until that stage
//   holds an item, then in_chan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_receiver_xor_check (
  input  wire          clk,
  input  wire          rst_n,
  efrx_in_if.sink      in_chan,
  efrx_out_if.source   out_chan
);

  localparam int IDX_W = efrx_pkg::IDX_W;
  localparam int CNT_W = efrx_pkg::CNT_W;

  // Frame buffer
  logic [7:0] frame_mem [efrx_pkg::FRAME_BYTES];

  // Frame state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       last_r, last_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       cmd_r, cmd_nxt;   // shadow of buffer byte 3
  logic [7:0]       sub_r, sub_nxt;   // shadow of buffer byte 4

  // Middle stage (result formed, read data being fetched)
  logic               s1_valid_r;
  efrx_pkg::status_t  s1_stat_r;
  logic               s1_rd_ok_r;
  logic [7:0]         rd_r;

  // Output stage
  logic               out_valid_r;
  efrx_pkg::status_t  out_stat_r;
  logic [7:0]         out_rd_r;

  logic in_acc, s1_move;

  // Working values for an accepted push
  logic             is_head, is_tail, is_esc, full;
  logic [CNT_W-1:0] cnt0, len;
  logic [7:0]       xor0, last0, cmd_eff, sub_eff;
  logic             ovf0;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       wr_data;
  logic             rd_ok;
  logic             push, has_result;
  efrx_pkg::status_t stat;

  assign s1_move        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || s1_move;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign push           = (in_chan.opcode == efrx_pkg::OP_PUSH);

  assign rd_ok = ({1'b0, in_chan.read_index} < 9'(efrx_pkg::FRAME_BYTES));

  always_comb begin
    is_head = (in_chan.rx_byte == efrx_pkg::HEAD_BYTE);
    is_tail = (in_chan.rx_byte == efrx_pkg::TAIL_BYTE);

    // a head restarts the frame before the byte is stored at index 0
    cnt0  = is_head ? '0 : cnt_r;
    xor0  = is_head ? '0 : xor_r;
    last0 = is_head ? '0 : last_r;
    ovf0  = is_head ? 1'b0 : ovf_r;

    full   = (cnt0 >= CNT_W'(efrx_pkg::FRAME_BYTES));
    // escape only once two bytes are stored, so byte 0 is never altered
    is_esc = (in_chan.rx_byte == efrx_pkg::ESC_BYTE) && (cnt0 >= CNT_W'(2))
             && (last0 >= efrx_pkg::ESC_MIN);

    cnt_nxt  = cnt0;
    xor_nxt  = xor0;
    last_nxt = last0;
    ovf_nxt  = ovf0;
    wr_en    = 1'b0;
    wr_idx   = cnt0[IDX_W-1:0];
    wr_data  = in_chan.rx_byte;

    if (is_esc) begin
      wr_en    = 1'b1;
      wr_idx   = IDX_W'(cnt0 - CNT_W'(1));
      wr_data  = last0 + efrx_pkg::ESC_ADD;
      last_nxt = last0 + efrx_pkg::ESC_ADD;
      xor_nxt  = xor0 ^ efrx_pkg::ESC_ADD;
    end else if (is_tail) begin
      wr_en    = !full;
      cnt_nxt  = '0;
      xor_nxt  = '0;
      last_nxt = '0;
      ovf_nxt  = 1'b0;
    end else if (full) begin
      ovf_nxt = 1'b1;
    end else begin
      wr_en    = 1'b1;
      cnt_nxt  = cnt0 + CNT_W'(1);
      xor_nxt  = (cnt0 != '0) ? (xor0 ^ in_chan.rx_byte) : xor0;
      last_nxt = in_chan.rx_byte;
    end

    // bytes 3 and 4 as they stand after this write
    cmd_eff = (wr_en && wr_idx == IDX_W'(3)) ? wr_data : cmd_r;
    sub_eff = (wr_en && wr_idx == IDX_W'(4)) ? wr_data : sub_r;
    cmd_nxt = cmd_eff;
    sub_nxt = sub_eff;

    len = full ? CNT_W'(efrx_pkg::FRAME_BYTES) : (cnt0 + CNT_W'(1));

    stat              = '0;
    stat.result_kind  = efrx_pkg::KIND_STATUS;
    stat.frame_valid  = !full && (len >= CNT_W'(4)) && (xor0 == '0);
    stat.command_code = (len > CNT_W'(3)) ? cmd_eff : '0;
    stat.sub_code     = (len > CNT_W'(4)) ? sub_eff : '0;
    stat.frame_length = efrx_pkg::LEN_W'(len);
    stat.overflowed   = full || ovf0;
    if (!push) begin
      stat             = '0;
      stat.result_kind = efrx_pkg::KIND_READ;
    end

    has_result = !push || (is_tail && !is_esc);
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      xor_r  <= '0;
      last_r <= '0;
      ovf_r  <= 1'b0;
    end else if (in_acc && push) begin
      cnt_r  <= cnt_nxt;
      xor_r  <= xor_nxt;
      last_r <= last_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && push) begin
      cmd_r <= cmd_nxt;
      sub_r <= sub_nxt;
    end
  end

  // Buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && push && wr_en) begin
      frame_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !push && rd_ok) begin
      rd_r <= frame_mem[in_chan.read_index[IDX_W-1:0]];
    end
  end

  // Middle stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= has_result;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_stat_r  <= stat;
      s1_rd_ok_r <= rd_ok;
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_stat_r <= s1_stat_r;
      out_rd_r   <= (s1_stat_r.result_kind == efrx_pkg::KIND_READ && s1_rd_ok_r)
                    ? rd_r : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_kind  = out_stat_r.result_kind;
  assign out_chan.frame_valid  = out_stat_r.frame_valid;
  assign out_chan.command_code = out_stat_r.command_code;
  assign out_chan.sub_code     = out_stat_r.sub_code;
  assign out_chan.frame_length = out_stat_r.frame_length;
  assign out_chan.overflowed   = out_stat_r.overflowed;
  assign out_chan.read_data    = out_rd_r;

  // Checks

  // count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(efrx_pkg::FRAME_BYTES))
    else $error("byte count beyond capacity");

  // a tail always closes the frame
  a_tail_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && push && is_tail) |=> (cnt_r == '0 && xor_r == '0 && !ovf_r))
    else $error("frame state not cleared after tail");

  // read answers carry no status
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r.result_kind == efrx_pkg::KIND_READ) |->
    (!out_stat_r.frame_valid && out_stat_r.frame_length == '0 &&
     !out_stat_r.overflowed))
    else $error("status fields set in read answer");

  // a held middle item blocks input while the output is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input taken while pipeline full");

endmodule

`default_nettype wire
